// File: design/vsr_pkg.sv
// Package for the varispeed stereo resampler: widths, register indexes, types.
// No dependencies; used by the top level and the lanes.
package vsr_pkg;

  localparam int DefWindowDepth = 1024;
  localparam int DefSampleBits  = 16;

  localparam int CfgIdxBits = 3;
  localparam int Tolerance = 655;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FIRST  = 3'd0,
    REG_FRAMES = 3'd1,
    REG_START  = 3'd2,
    REG_INIT   = 3'd3,
    REG_TARGET = 3'd4,
    REG_GLIDE  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LERP,
    ST_DIV,
    ST_DONE
  } state_t;

  // Lane control from the sequencer
  typedef struct packed {
    logic start;
    logic latch;
    logic oow;
  } lane_ctrl_t;

endpackage

// File: design/varispeed_stereo_resampler.sv
// Top level of the varispeed stereo resampler: sequencer, position/speed state,
// two channel lanes and the result register. Depends on vsr_pkg and submodules.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | cmd, write_index, write_left, write_right
//  out     | out_valid | out_stall | out_left, out_right, out_of_window,
//          |           |           | position_frame
//
// A write item leaves the sequencer idle; any other state stalls the input.
// A produce item: memory read and multiply (READ), interpolation (LERP), the
// glide divide of 24 quotient bits plus the commit (DIV), then DONE.
// Out-of-window items skip the divide, going from LERP straight to DONE.
// Reset (rst, synchronous) restores the sequencer, configuration, position,
// speed and out_valid; data registers are not reset; the window is undefined.
// A result waits in the output register; the next item enters meanwhile, but a
// new result waits until the old one has gone.
module varispeed_stereo_resampler #(
  parameter int WINDOW_DEPTH = vsr_pkg::DefWindowDepth,
  parameter int SAMPLE_BITS  = vsr_pkg::DefSampleBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [9:0]  write_index,
  input  logic signed [15:0] write_left,
  input  logic signed [15:0] write_right,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic        out_of_window,
  output logic [31:0] position_frame,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  localparam int AW = $clog2(WINDOW_DEPTH);

  vsr_pkg::state_t state, state_next;

  logic [31:0] window_first_frame;
  logic [10:0] window_frames;
  logic signed [23:0] target_speed;
  logic [15:0] glide_frames;
  logic [47:0] play_position;
  logic signed [23:0] current_speed;

  logic        in_acc, oow, oow_hold;
  logic [32:0] fl, ce, end_frame;
  logic [16:0] frames;
  logic [15:0] frac;
  logic [AW-1:0] i0, i1;
  logic        wr_ok;
  vsr_pkg::lane_ctrl_t ctrl;
  logic signed [15:0] left_s, right_s;
  logic signed [24:0] d;
  logic [23:0] mag, step;
  logic        div_busy, div_start;
  logic signed [49:0] np;

  assign in_acc = in_valid && !in_stall;

  // Addressing and window test from the current position
  assign fl    = {1'b0, play_position[47:16]};
  assign frac  = play_position[15:0];
  assign ce    = fl + 33'(frac != '0);
  assign frames = (17'(window_frames) < 17'(WINDOW_DEPTH)) ? 17'(window_frames)
                                                             : 17'(WINDOW_DEPTH);
  assign end_frame = {1'b0, window_first_frame} + 33'(frames);
  assign oow = (ce >= end_frame) || (fl < {1'b0, window_first_frame});
  assign i0 = AW'(fl - {1'b0, window_first_frame});
  assign i1 = AW'(ce - {1'b0, window_first_frame});
  assign wr_ok = in_acc && !cmd && (32'(write_index) < 32'(WINDOW_DEPTH));

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      vsr_pkg::ST_IDLE: if (in_acc && cmd) state_next = vsr_pkg::ST_READ;
      vsr_pkg::ST_READ: state_next = vsr_pkg::ST_LERP;
      vsr_pkg::ST_LERP: state_next = oow ? vsr_pkg::ST_DONE : vsr_pkg::ST_DIV;
      vsr_pkg::ST_DIV:  if (!div_busy) state_next = vsr_pkg::ST_DONE;
      vsr_pkg::ST_DONE: if (!(out_valid && out_stall)) state_next = vsr_pkg::ST_IDLE;
      default: state_next = vsr_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer; samples and window flag are taken in LERP,
  // before the position moves
  always_comb begin
    in_stall   = (state != vsr_pkg::ST_IDLE);
    ctrl.start = (state == vsr_pkg::ST_READ);
    ctrl.latch = (state == vsr_pkg::ST_LERP);
    ctrl.oow   = oow;
    div_start  = (state == vsr_pkg::ST_LERP) && !oow;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= vsr_pkg::ST_IDLE;
    else state <= state_next;
  end

  vsr_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_left (
    .clk, .wr_en(wr_ok), .wr_addr(AW'(write_index)), .wr_data(write_left),
    .rd_addr0(i0), .rd_addr1(i1), .frac, .ctrl, .sample(left_s)
  );
  vsr_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_right (
    .clk, .wr_en(wr_ok), .wr_addr(AW'(write_index)), .wr_data(write_right),
    .rd_addr0(i0), .rd_addr1(i1), .frac, .ctrl, .sample(right_s)
  );

  // Glide: |speed - target| / glide length
  assign d   = 25'(current_speed) - 25'(target_speed);
  assign mag = d[24] ? 24'(-d) : 24'(d);

  vsr_divider u_div (
    .clk, .rst, .start(div_start), .dividend(mag), .divisor(glide_frames),
    .busy(div_busy), .quotient(step)
  );

  assign np = 50'(play_position) + 50'(current_speed);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_first_frame <= '0;
      window_frames      <= '0;
      target_speed       <= 24'sd65536;
      glide_frames       <= 16'd1;
      play_position      <= '0;
      current_speed      <= 24'sd65536;
    end else begin
      if (cfg_we) begin
        case (vsr_pkg::reg_idx_t'(cfg_index))
          vsr_pkg::REG_FIRST:  window_first_frame <= cfg_data[31:0];
          vsr_pkg::REG_FRAMES: window_frames <= cfg_data[10:0];
          vsr_pkg::REG_START:  play_position <= cfg_data;
          vsr_pkg::REG_INIT:   current_speed <= cfg_data[23:0];
          vsr_pkg::REG_TARGET: target_speed <= cfg_data[23:0];
          vsr_pkg::REG_GLIDE:  glide_frames <= cfg_data[15:0];
          default: ;
        endcase
      end
      // Commit the step once the divide is done
      if (state == vsr_pkg::ST_DIV && !div_busy) begin
        if (np < 0) play_position <= '0;
        else if (np > 50'sh0FFFF_FFFF_FFFF) play_position <= '1;
        else play_position <= np[47:0];
        if ($signed({1'b0, mag}) <= 25'(vsr_pkg::Tolerance)) current_speed <= target_speed;
        else if (!d[24]) current_speed <= current_speed - $signed(step);
        else current_speed <= current_speed + $signed(step);
      end
    end
  end

  // Window flag of the item, taken with the samples
  always_ff @(posedge clk) begin
    if (state == vsr_pkg::ST_LERP) oow_hold <= oow;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == vsr_pkg::ST_DONE && !(out_valid && out_stall)) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == vsr_pkg::ST_DONE && !(out_valid && out_stall)) begin
      out_left       <= left_s;
      out_right      <= right_s;
      out_of_window  <= oow_hold;
      position_frame <= play_position[47:16];
    end
  end
endmodule

// File: design/vsr_lane.sv
// One channel lane: window memory, registered reads and linear interpolation.
// Depends on vsr_pkg.
module vsr_lane #(
  parameter int WINDOW_DEPTH = vsr_pkg::DefWindowDepth,
  parameter int SAMPLE_BITS  = vsr_pkg::DefSampleBits,
  localparam int AW = $clog2(WINDOW_DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [15:0]   wr_data,
  input  logic [AW-1:0]        rd_addr0,
  input  logic [AW-1:0]        rd_addr1,
  input  logic [15:0]          frac,
  input  vsr_pkg::lane_ctrl_t  ctrl,
  output logic signed [15:0]   sample
);
  localparam int SB = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam logic signed [16:0] SHi = 17'sd1 <<< (SB - 1);

  logic signed [15:0] mem [WINDOW_DEPTH];
  logic signed [15:0] a, b;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [33:0] acc;
  logic signed [17:0] q;
  logic signed [15:0] wsat;

  // Stored samples saturate to SAMPLE_BITS
  always_comb begin
    if ($signed({wr_data[15], wr_data}) > SHi - 17'sd1) wsat = 16'(SHi - 17'sd1);
    else if ($signed({wr_data[15], wr_data}) < -SHi) wsat = 16'(-SHi);
    else wsat = wr_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wsat;
    a <= mem[rd_addr0];
    b <= mem[rd_addr1];
  end

  assign diff = 17'(b) - 17'(a);

  always_ff @(posedge clk) begin
    if (ctrl.start) prod <= $signed({18'd0, frac}) * 34'(diff);
  end

  // a * 65536, sign-extended, plus the weighted difference
  assign acc = 34'($signed({a, 16'd0})) + prod;
  assign q = acc[33:16];

  // Sample is taken once per item and held until the next one
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      if (ctrl.oow) sample <= '0;
      else if (q > 18'(SHi - 17'sd1)) sample <= 16'(SHi - 17'sd1);
      else if (q < -18'(SHi)) sample <= 16'(-SHi);
      else sample <= q[15:0];
    end
  end
endmodule

// File: design/vsr_divider.sv
// Restoring divider, one quotient bit per cycle, for the glide step.
// No dependencies.
module vsr_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [23:0] quotient
);
  logic [4:0]  count;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [16:0] trial;

  assign trial = {rem[15:0], quotient[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= 5'd24;
      rem      <= '0;
      quotient <= dividend;
      dvs      <= (divisor == '0) ? 16'd1 : divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= trial - {1'b0, dvs};
        quotient <= {quotient[22:0], 1'b1};
      end else begin
        rem      <= trial;
        quotient <= {quotient[22:0], 1'b0};
      end
      count <= count - 5'd1;
      if (count == 5'd1) busy <= 1'b0;
    end
  end
endmodule

// File: design/vsr_checker.sv
// Port-level checker for the varispeed stereo resampler, bound to the top level.
// Depends only on the top-level ports.
module vsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [15:0] out_left,
  input logic signed [15:0] out_right,
  input logic        out_of_window
);
  a_oow_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_window |-> out_left == '0 && out_right == '0)
    else $error("out-of-window item with non-zero samples");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_left))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result valid or input stalled after reset");

  a_hold_rest: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_right) && $stable(out_of_window))
    else $error("stalled result changed");
endmodule

bind varispeed_stereo_resampler vsr_checker u_vsr_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall,
  .out_left, .out_right, .out_of_window
);
